### rtl/core/l34ck_pkg.sv
// ----------------------------------------------------------------------------
// l34ck_pkg
// Shared types, codes and helpers for the L3/L4 checksum recompute block.
// ----------------------------------------------------------------------------
package l34ck_pkg;

	// IP protocol numbers handled by the block
	localparam logic [7:0] PR_HDR   = 8'd0;
	localparam logic [7:0] PR_ICMP  = 8'd1;
	localparam logic [7:0] PR_TCP   = 8'd6;
	localparam logic [7:0] PR_UDP   = 8'd17;
	localparam logic [7:0] PR_ICMP6 = 8'd58;

	localparam logic [16:0] POS_MAX      = 17'h1FFFF;
	localparam logic [5:0]  V6_HDR_BYTES = 6'd40;
	localparam logic [6:0]  V4_HCS_OFF   = 7'd10;
	localparam logic [3:0]  IP_VER_SIX   = 4'd6;

	// result status
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_LEN_BAD  = 3'd1,
		ST_L4_SHORT = 3'd2,
		ST_UNSUP    = 3'd3,
		ST_TRUNC    = 3'd4
	} status_t;

	// one accepted input word
	typedef struct packed {
		logic [7:0]  data;
		logic        first;
		logic        last;
		logic [15:0] len;
		logic [7:0]  hint;
	} in_item_t;

	// packet state snapshot taken at the last byte
	typedef struct packed {
		logic [15:0] sum;
		logic [16:0] count;
		logic        v6;
		logic [5:0]  hl;
		logic [7:0]  proto;
		logic [15:0] len;
		logic        udp_nz;
	} fin_t;

	// one result word
	typedef struct packed {
		logic [15:0] value;
		logic [15:0] offset;
		logic        wr;
		status_t     status;
	} res_t;

	// ones-complement add with end-around carry
	function automatic logic [15:0] add1c(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[15:0] + {15'b0, t[16]};
	endfunction

	function automatic logic is_l4(input logic [7:0] p);
		return (p == PR_ICMP) || (p == PR_TCP) || (p == PR_UDP) || (p == PR_ICMP6);
	endfunction

	// checksum field offset for a protocol with a field
	function automatic logic [6:0] fld_off(input logic [7:0] p, input logic [5:0] hl);
		logic [6:0] r;
		case (p)
			PR_TCP:   r = {1'b0, hl} + 7'd16;
			PR_UDP:   r = {1'b0, hl} + 7'd6;
			PR_ICMP,
			PR_ICMP6: r = {1'b0, hl} + 7'd2;
			default:  r = V4_HCS_OFF;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/l3_l4_checksum_recompute.sv
// ----------------------------------------------------------------------------
// l3_l4_checksum_recompute
// Streaming IP header / TCP / UDP / ICMP / ICMPv6 checksum recompute.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle unless a last byte waits for the snapshot stage;
//   each byte costs one pass of the accumulator.
// Path: input register, accumulate and snapshot, finish into the output register.
// Reset: arst_n clears the pipeline valids and the packet state at once;
//   the first byte after reset starts a packet.
module l3_l4_checksum_recompute (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        last_byte,
	input  logic [15:0] l4_length,
	input  logic [7:0]  proto_hint,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] checksum_value,
	output logic [15:0] write_offset,
	output logic        write_valid,
	output logic [2:0]  status_code
);

	l34ck_pkg::in_item_t item_s1;
	logic                v_s1;
	l34ck_pkg::fin_t     fin;
	l34ck_pkg::fin_t     fin_s2;
	logic                v_s2;
	l34ck_pkg::res_t     res;
	l34ck_pkg::res_t     res_q;
	logic                out_load;
	logic                s2_free;
	logic                go;

	// stage handshake
	assign out_load = v_s2 && (!out_valid || out_ready);
	assign s2_free  = !v_s2 || out_load;
	assign go       = v_s1 && (!item_s1.last || s2_free);
	assign in_ready = !v_s1 || go;

	// valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				v_s1 <= 1'b1;
			end else if (go) begin
				v_s1 <= 1'b0;
			end
			if (go && item_s1.last) begin
				v_s2 <= 1'b1;
			end else if (out_load) begin
				v_s2 <= 1'b0;
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.data  <= data_byte;
			item_s1.first <= first_byte;
			item_s1.last  <= last_byte;
			item_s1.len   <= l4_length;
			item_s1.hint  <= proto_hint;
		end
		if (go && item_s1.last) begin
			fin_s2 <= fin;
		end
		if (out_load) begin
			res_q <= res;
		end
	end

	l34ck_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.item   (item_s1),
		.fin    (fin)
	);

	l34ck_finish u_finish (
		.fin (fin_s2),
		.res (res)
	);

	// result word
	assign checksum_value = res_q.value;
	assign write_offset   = res_q.offset;
	assign write_valid    = res_q.wr;
	assign status_code    = res_q.status;

	// checks
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1)
		else $error("input stalled with empty input register");

	a_no_write_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_valid |-> (checksum_value == 16'd0) && (write_offset == 16'd0))
		else $error("unwritten result carries nonzero fields");

	a_write_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_valid |-> (status_code == 3'(l34ck_pkg::ST_OK)))
		else $error("write requested with error status");

	a_s2_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && out_valid && !out_ready |=> v_s2)
		else $error("snapshot lost while output stalled");

endmodule

### rtl/core/l34ck_accum.sv
// ----------------------------------------------------------------------------
// l34ck_accum
// Per-byte packet tracking and ones-complement accumulation.
// ----------------------------------------------------------------------------
module l34ck_accum (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  l34ck_pkg::in_item_t item,
	output l34ck_pkg::fin_t     fin
);

	logic [15:0] sum_q;
	logic [16:0] pos_q;
	logic        v6_q;
	logic [5:0]  hl_q;
	logic [7:0]  proto_q;
	logic [15:0] len_q;
	logic        udp_nz_q;

	logic        start;
	logic        v6_e;
	logic [5:0]  hl_e;
	logic [7:0]  proto_e;
	logic [15:0] len_e;
	logic [15:0] sum_e;
	logic        udp_nz_e;
	logic [16:0] p;
	logic [16:0] end_pos;
	logic        has_off;
	logic [6:0]  off;
	logic        in_field;
	logic [7:0]  b;
	logic [15:0] word;
	logic        r_hdr;
	logic        r_l4;
	logic [15:0] sum_a;
	logic [15:0] sum_b;
	logic [16:0] pos_nx;

	// packet start and per-packet fields for this byte
	always_comb begin
		start    = item.first || (pos_q == '0);
		p        = start ? '0 : pos_q;
		v6_e     = start ? (item.data[7:4] == l34ck_pkg::IP_VER_SIX) : v6_q;
		hl_e     = start ? (v6_e ? l34ck_pkg::V6_HDR_BYTES : {item.data[3:0], 2'b00}) : hl_q;
		len_e    = start ? item.len : len_q;
		sum_e    = start ? '0 : sum_q;
		if (start) begin
			proto_e = v6_e ? l34ck_pkg::PR_HDR : item.hint;
		end else begin
			proto_e = proto_q;
		end
		// IPv6 next header byte
		if (v6_e && (p == 17'd6)) begin
			proto_e = item.data;
		end
		end_pos = {11'b0, hl_e} + {1'b0, len_e};
	end

	// old checksum field reads as zero
	always_comb begin
		has_off  = l34ck_pkg::is_l4(proto_e) || ((proto_e == l34ck_pkg::PR_HDR) && !v6_e);
		off      = l34ck_pkg::fld_off(proto_e, hl_e);
		in_field = has_off && ((p == {10'b0, off}) || (p == {10'b0, off} + 17'd1));
		b        = item.data;
		udp_nz_e = start ? 1'b0 : udp_nz_q;
		if (in_field) begin
			if ((proto_e == l34ck_pkg::PR_UDP) && (item.data != 8'd0)) begin
				udp_nz_e = 1'b1;
			end
			b = 8'd0;
		end
		word = p[0] ? {8'b0, b} : {b, 8'b0};
	end

	// regions the byte belongs to; each adds the word once
	always_comb begin
		if (v6_e) begin
			r_hdr = l34ck_pkg::is_l4(proto_e) && (p >= 17'd8) && (p < 17'd40);
		end else begin
			r_hdr = ((proto_e == l34ck_pkg::PR_HDR) && (p < {11'b0, hl_e})) ||
			        (((proto_e == l34ck_pkg::PR_TCP) || (proto_e == l34ck_pkg::PR_UDP)) &&
			         (p >= 17'd12) && (p < 17'd20));
		end
		r_l4   = l34ck_pkg::is_l4(proto_e) && (p >= {11'b0, hl_e}) && (p < end_pos);
		sum_a  = r_hdr ? l34ck_pkg::add1c(sum_e, word) : sum_e;
		sum_b  = r_l4 ? l34ck_pkg::add1c(sum_a, word) : sum_a;
		pos_nx = (p < l34ck_pkg::POS_MAX) ? p + 17'd1 : p;
	end

	// snapshot for the finishing stage
	always_comb begin
		fin.sum    = sum_b;
		fin.count  = pos_nx;
		fin.v6     = v6_e;
		fin.hl     = hl_e;
		fin.proto  = proto_e;
		fin.len    = len_e;
		fin.udp_nz = udp_nz_e;
	end

	// packet state; cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			pos_q    <= '0;
			v6_q     <= 1'b0;
			hl_q     <= '0;
			proto_q  <= '0;
			len_q    <= '0;
			udp_nz_q <= 1'b0;
		end else if (go) begin
			if (item.last) begin
				sum_q    <= '0;
				pos_q    <= '0;
				v6_q     <= 1'b0;
				hl_q     <= '0;
				proto_q  <= '0;
				len_q    <= '0;
				udp_nz_q <= 1'b0;
			end else begin
				sum_q    <= sum_b;
				pos_q    <= pos_nx;
				v6_q     <= v6_e;
				hl_q     <= hl_e;
				proto_q  <= proto_e;
				len_q    <= len_e;
				udp_nz_q <= udp_nz_e;
			end
		end
	end

endmodule

### rtl/core/l34ck_finish.sv
// ----------------------------------------------------------------------------
// l34ck_finish
// Status decision and final checksum from the end-of-packet snapshot.
// ----------------------------------------------------------------------------
module l34ck_finish (
	input  l34ck_pkg::fin_t fin,
	output l34ck_pkg::res_t res
);

	logic [16:0] end_pos;
	logic [15:0] min_len;
	logic [15:0] s_a;
	logic [15:0] s_b;
	logic [15:0] s_f;
	logic [15:0] val;

	// pseudo-header protocol and length words (not for ICMP), final value, minimum L4 length
	always_comb begin
		end_pos = {11'b0, fin.hl} + {1'b0, fin.len};
		s_a     = l34ck_pkg::add1c(fin.sum, {8'b0, fin.proto});
		s_b     = l34ck_pkg::add1c(s_a, fin.len);
		s_f     = (fin.proto != l34ck_pkg::PR_ICMP) ? s_b : fin.sum;
		val     = ~s_f;
		if ((fin.proto == l34ck_pkg::PR_UDP) && (val == 16'd0)) begin
			val = 16'hFFFF;
		end
		case (fin.proto)
			l34ck_pkg::PR_TCP: min_len = 16'd20;
			l34ck_pkg::PR_UDP: min_len = 16'd8;
			default:           min_len = 16'd4;
		endcase
	end

	// status in priority order
	always_comb begin
		res.value  = '0;
		res.offset = '0;
		res.wr     = 1'b0;
		res.status = l34ck_pkg::ST_OK;
		if ((fin.len < 16'd20) || (fin.v6 && (fin.len < 16'd40))) begin
			res.status = l34ck_pkg::ST_LEN_BAD;
		end else if (fin.v6 && (fin.count < 17'd7)) begin
			res.status = l34ck_pkg::ST_TRUNC;
		end else if (fin.proto == l34ck_pkg::PR_HDR) begin
			if (!fin.v6) begin
				if (fin.count < {11'b0, fin.hl}) begin
					res.status = l34ck_pkg::ST_TRUNC;
				end else begin
					res.value  = ~fin.sum;
					res.offset = {9'b0, l34ck_pkg::V4_HCS_OFF};
					res.wr     = 1'b1;
				end
			end
		end else if (!l34ck_pkg::is_l4(fin.proto)) begin
			res.status = l34ck_pkg::ST_UNSUP;
		end else if (fin.len < min_len) begin
			res.status = l34ck_pkg::ST_L4_SHORT;
		end else if (fin.count < end_pos) begin
			res.status = l34ck_pkg::ST_TRUNC;
		end else if (!((fin.proto == l34ck_pkg::PR_UDP) && !fin.udp_nz)) begin
			res.value  = val;
			res.offset = {9'b0, l34ck_pkg::fld_off(fin.proto, fin.hl)};
			res.wr     = 1'b1;
		end
	end

endmodule

### tb/l3_l4_checksum_recompute_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// l3_l4_checksum_recompute_tb
// Streams IPv4 and IPv6 packets one byte per word into the checksum block.
// A local model of the checksum recompute predicts the result word of each closed
// packet, and every result word is checked field by field. Both handshakes
// idle in random bursts.
// ----------------------------------------------------------------------------
module l3_l4_checksum_recompute_tb;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        first_byte = 1'b0;
	logic        last_byte = 1'b0;
	logic [15:0] l4_length = 16'h0000;
	logic [7:0]  proto_hint = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] checksum_value;
	logic [15:0] write_offset;
	logic        write_valid;
	logic [2:0]  status_code;

	// stimulus and expected results
	l34ck_pkg::in_item_t tx_bytes[$];
	l34ck_pkg::res_t     csum_due[$];
	l34ck_pkg::in_item_t cur_item;
	l34ck_pkg::res_t     want_res;
	int       n_closed = 0;
	int       n_sent = 0;
	int       n_res = 0;
	int       n_err = 0;
	int       quiet_at = 32'h7fffffff;
	int       gap_left = 0;
	int       stall_left = 0;
	logic     calm = 1'b0;
	logic     quiet = 1'b0;

	// packet state of the local model
	logic [15:0] ck_sum;
	logic [16:0] ck_pos;
	logic        ck_v6;
	logic [5:0]  ck_hl;
	logic [7:0]  ck_proto;
	logic [15:0] ck_len;
	logic        ck_udp_nz;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	l3_l4_checksum_recompute u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.first_byte    (first_byte),
		.last_byte     (last_byte),
		.l4_length     (l4_length),
		.proto_hint    (proto_hint),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.checksum_value(checksum_value),
		.write_offset  (write_offset),
		.write_valid   (write_valid),
		.status_code   (status_code)
	);

	// ------------------------------------------------------------------------
	// checksum model
	// ------------------------------------------------------------------------
	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [17:0] t;
		t = a + b;
		while (t > 18'hffff)
			t = t[15:0] + t[17:16];
		return t[15:0];
	endfunction

	function automatic bit l4_kind(input logic [7:0] p);
		return p == l34ck_pkg::PR_ICMP || p == l34ck_pkg::PR_TCP ||
			p == l34ck_pkg::PR_UDP || p == l34ck_pkg::PR_ICMP6;
	endfunction

	// where the checksum field sits; 0 if the packet has none
	function automatic bit csum_field(output int off);
		off = 0;
		case (ck_proto)
			l34ck_pkg::PR_TCP: begin
				off = ck_hl + 16;
				return 1'b1;
			end
			l34ck_pkg::PR_UDP: begin
				off = ck_hl + 6;
				return 1'b1;
			end
			l34ck_pkg::PR_ICMP, l34ck_pkg::PR_ICMP6: begin
				off = ck_hl + 2;
				return 1'b1;
			end
			l34ck_pkg::PR_HDR: begin
				if (ck_v6)
					return 1'b0;
				off = l34ck_pkg::V4_HCS_OFF;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic void csum_clear();
		ck_sum = '0;
		ck_pos = '0;
		ck_v6 = 1'b0;
		ck_hl = '0;
		ck_proto = '0;
		ck_len = '0;
		ck_udp_nz = 1'b0;
	endfunction

	// add one accepted byte; at the last byte, queue the due result
	task automatic csum_take_byte(input l34ck_pkg::in_item_t it);
		logic [7:0]  b;
		logic [15:0] word;
		logic [15:0] s;
		int          p, fend, off, roles, cnt, minlen;
		l34ck_pkg::res_t r;
		bit          has_off;
		b = it.data;
		if (it.first || ck_pos == 0) begin
			csum_clear();
			ck_v6 = (b[7:4] == l34ck_pkg::IP_VER_SIX);
			ck_hl = ck_v6 ? l34ck_pkg::V6_HDR_BYTES : {b[3:0], 2'b00};
			ck_proto = ck_v6 ? l34ck_pkg::PR_HDR : it.hint;
			ck_len = it.len;
		end
		p = ck_pos;
		if (ck_v6 && p == 6)
			ck_proto = b;
		fend = ck_hl + ck_len;

		// old checksum field reads as zero
		has_off = csum_field(off);
		if (has_off && (p == off || p == off + 1)) begin
			if (ck_proto == l34ck_pkg::PR_UDP && b != 8'h00)
				ck_udp_nz = 1'b1;
			b = 8'h00;
		end

		// one add per region the byte falls in
		roles = 0;
		if (ck_v6) begin
			if (l4_kind(ck_proto) && p >= 8 && p < 40)
				roles++;
		end else begin
			if (ck_proto == l34ck_pkg::PR_HDR && p < ck_hl)
				roles++;
			if ((ck_proto == l34ck_pkg::PR_TCP || ck_proto == l34ck_pkg::PR_UDP) &&
					p >= 12 && p < 20)
				roles++;
		end
		if (l4_kind(ck_proto) && p >= ck_hl && p < fend)
			roles++;
		word = p[0] ? {8'h00, b} : {b, 8'h00};
		repeat (roles)
			ck_sum = ones_add(ck_sum, word);
		if (ck_pos != l34ck_pkg::POS_MAX)
			ck_pos = ck_pos + 1'b1;

		if (!it.last)
			return;

		// finish the packet
		cnt = ck_pos;
		r = '0;
		r.status = l34ck_pkg::ST_OK;
		if (ck_len < 20 || (ck_v6 && ck_len < 40)) begin
			r.status = l34ck_pkg::ST_LEN_BAD;
		end else if (ck_v6 && cnt < 7) begin
			r.status = l34ck_pkg::ST_TRUNC;
		end else if (ck_proto == l34ck_pkg::PR_HDR) begin
			if (!ck_v6) begin
				if (cnt < ck_hl) begin
					r.status = l34ck_pkg::ST_TRUNC;
				end else begin
					r.value = ~ck_sum;
					r.offset = 16'(l34ck_pkg::V4_HCS_OFF);
					r.wr = 1'b1;
				end
			end
		end else if (!l4_kind(ck_proto)) begin
			r.status = l34ck_pkg::ST_UNSUP;
		end else begin
			minlen = (ck_proto == l34ck_pkg::PR_TCP) ? 20 :
				(ck_proto == l34ck_pkg::PR_UDP) ? 8 : 4;
			if (ck_len < minlen) begin
				r.status = l34ck_pkg::ST_L4_SHORT;
			end else if (cnt < fend) begin
				r.status = l34ck_pkg::ST_TRUNC;
			end else if (!(ck_proto == l34ck_pkg::PR_UDP && !ck_udp_nz)) begin
				s = ck_sum;
				if (ck_proto != l34ck_pkg::PR_ICMP) begin
					s = ones_add(s, {8'h00, ck_proto});
					s = ones_add(s, ck_len);
				end
				r.value = ~s;
				// a zero UDP checksum goes out as all ones
				if (ck_proto == l34ck_pkg::PR_UDP && r.value == 16'h0000)
					r.value = 16'hffff;
				has_off = csum_field(off);
				r.offset = 16'(off);
				r.wr = 1'b1;
			end
		end
		csum_due.push_back(r);
		csum_clear();
	endtask

	// ------------------------------------------------------------------------
	// packet builders
	// ------------------------------------------------------------------------
	// header fields ride on the first byte; later bytes carry noise there
	task automatic push_bytes(input logic [7:0] pk[$], input logic [15:0] len,
			input logic [7:0] hint, input bit mark_first, input bit close);
		l34ck_pkg::in_item_t it;
		foreach (pk[i]) begin
			it.data = pk[i];
			it.first = (i == 0) ? mark_first : 1'b0;
			it.last = close && (i == pk.size() - 1);
			it.len = (i == 0) ? len : 16'($urandom);
			it.hint = (i == 0) ? hint : 8'($urandom);
			tx_bytes.push_back(it);
		end
		if (close)
			n_closed++;
	endtask

	// udp_mode: 0 random, 1 zero old UDP checksum, 2 nonzero old UDP checksum
	task automatic push_packet(input bit v6, input logic [3:0] ihl, input logic [7:0] proto,
			input logic [15:0] len, input int nbytes, input int udp_mode,
			input bit mark_first, input bit close);
		logic [7:0] pk[$];
		logic [3:0] ver;
		int         hl, i;
		hl = v6 ? 40 : ihl * 4;
		for (i = 0; i < nbytes; i++)
			pk.push_back(8'($urandom));
		ver = 4'd4;
		if (v6) begin
			ver = l34ck_pkg::IP_VER_SIX;
		end else if ($urandom_range(0, 9) == 0) begin
			ver = 4'($urandom);
			if (ver == l34ck_pkg::IP_VER_SIX)
				ver = 4'd5;
		end
		if (nbytes > 0)
			pk[0] = {ver, v6 ? 4'($urandom) : ihl};
		if (v6 && nbytes > 6)
			pk[6] = proto;
		if (udp_mode != 0 && nbytes > hl + 7) begin
			pk[hl + 6] = (udp_mode == 1) ? 8'h00 : 8'($urandom_range(1, 255));
			pk[hl + 7] = (udp_mode == 1) ? 8'h00 : 8'($urandom);
		end
		push_bytes(pk, len, v6 ? 8'($urandom) : proto, mark_first, close);
	endtask

	// mostly well-formed packets, some cut short, padded or malformed
	task automatic push_random_packet(input bit closing);
		bit         v6;
		logic [3:0] ihl;
		logic [7:0] proto;
		logic [15:0] len;
		int         hl, full, nbytes, pick;
		v6 = ($urandom_range(0, 3) == 0);
		pick = $urandom_range(0, 15);
		case (pick)
			0, 1:     proto = l34ck_pkg::PR_HDR;
			2, 3:     proto = l34ck_pkg::PR_ICMP;
			4, 5, 6:  proto = l34ck_pkg::PR_TCP;
			7, 8, 9:  proto = l34ck_pkg::PR_UDP;
			10, 11:   proto = l34ck_pkg::PR_ICMP6;
			default:  proto = 8'($urandom);
		endcase
		ihl = 4'd5;
		pick = $urandom_range(0, 19);
		if (pick < 3)
			ihl = 4'($urandom_range(6, 15));
		else if (pick == 3)
			ihl = 4'($urandom_range(0, 4));
		hl = v6 ? 40 : ihl * 4;
		pick = $urandom_range(0, 29);
		if (pick < 3)
			len = 16'($urandom_range(0, v6 ? 39 : 19));
		else if (pick == 3)
			len = 16'($urandom);
		else
			len = 16'(v6 ? $urandom_range(40, 64) : $urandom_range(20, 44));
		full = hl + len;
		pick = $urandom_range(0, 19);
		if (full > 200)
			nbytes = hl + $urandom_range(0, 40);
		else if (pick < 3)
			nbytes = $urandom_range(1, (full > 1) ? full - 1 : 1);
		else if (pick < 6)
			nbytes = full + $urandom_range(1, 4);
		else
			nbytes = full;
		if (nbytes < 1)
			nbytes = 1;
		push_packet(v6, ihl, proto, len, nbytes, ($urandom_range(0, 3) == 0) ? 1 : 0,
			closing || $urandom_range(0, 9) != 0, closing || $urandom_range(0, 19) != 0);
	endtask

	// ------------------------------------------------------------------------
	// input driver
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				csum_take_byte(cur_item);
				n_sent++;
				if (n_sent >= quiet_at)
					quiet <= 1'b1;
				if ($urandom_range(0, 99) == 0)
					calm <= !calm;
			end
			// next word once the slot is free
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (!calm && !quiet && $urandom_range(0, 7) == 0) begin
					gap_left = $urandom_range(0, 15);
					in_valid <= 1'b0;
				end else if (tx_bytes.size() != 0) begin
					cur_item = tx_bytes.pop_front();
					data_byte <= cur_item.data;
					first_byte <= cur_item.first;
					last_byte <= cur_item.last;
					l4_length <= cur_item.len;
					proto_hint <= cur_item.hint;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// result monitor
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (csum_due.size() == 0) begin
					n_err++;
					if (n_err <= 10)
						$display("ERROR: unexpected result value=%h offset=%0d wr=%b status=%0d",
							checksum_value, write_offset, write_valid, status_code);
				end else begin
					want_res = csum_due.pop_front();
					if (checksum_value !== want_res.value || write_offset !== want_res.offset ||
							write_valid !== want_res.wr || status_code !== want_res.status) begin
						n_err++;
						if (n_err <= 10)
							$display({"ERROR: result %0d expected value=%h offset=%0d wr=%b ",
								"status=%0d, got value=%h offset=%0d wr=%b status=%0d"},
								n_res, want_res.value, want_res.offset, want_res.wr,
								want_res.status, checksum_value, write_offset, write_valid,
								status_code);
					end
				end
				n_res++;
			end
			// receiver back-pressure
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!calm && !quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 15);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		logic [7:0] pk[$];
		int         i;
		csum_clear();

		// directed packets
		push_packet(0, 4'd5, l34ck_pkg::PR_HDR, 16'd20, 20, 0, 1, 1);
		push_packet(0, 4'd15, l34ck_pkg::PR_HDR, 16'd20, 60, 0, 1, 1);  // longest IPv4 header
		push_packet(0, 4'd5, l34ck_pkg::PR_HDR, 16'd20, 12, 0, 1, 1);   // header cut short
		push_packet(0, 4'd5, l34ck_pkg::PR_TCP, 16'd20, 40, 0, 1, 1);
		push_packet(0, 4'd5, l34ck_pkg::PR_UDP, 16'd20, 40, 1, 1, 1);   // UDP checksum off
		push_packet(0, 4'd5, l34ck_pkg::PR_UDP, 16'd20, 40, 2, 1, 1);
		push_packet(0, 4'd5, l34ck_pkg::PR_ICMP, 16'd20, 44, 0, 1, 1);  // bytes past the end
		push_packet(0, 4'd5, l34ck_pkg::PR_ICMP6, 16'd20, 40, 0, 1, 1);
		push_packet(0, 4'd1, l34ck_pkg::PR_TCP, 16'd20, 24, 0, 0, 1);   // tiny IHL, no first mark
		push_packet(0, 4'd5, 8'hff, 16'd20, 40, 0, 1, 1);               // unsupported protocol
		push_packet(0, 4'd5, l34ck_pkg::PR_TCP, 16'hffff, 30, 0, 1, 1); // truncated
		push_packet(0, 4'd0, l34ck_pkg::PR_TCP, 16'd0, 1, 0, 1, 1);     // single-byte packet
		push_packet(1, 4'd0, l34ck_pkg::PR_TCP, 16'd40, 80, 0, 1, 1);
		push_packet(1, 4'd0, l34ck_pkg::PR_UDP, 16'd40, 80, 2, 1, 1);
		push_packet(1, 4'd0, l34ck_pkg::PR_ICMP6, 16'd40, 80, 0, 1, 1);
		push_packet(1, 4'd0, l34ck_pkg::PR_ICMP, 16'd40, 80, 0, 1, 1);
		push_packet(1, 4'd0, l34ck_pkg::PR_HDR, 16'd40, 80, 0, 1, 1);   // IPv6, nothing written
		push_packet(1, 4'd0, l34ck_pkg::PR_TCP, 16'd40, 5, 0, 1, 1);    // ends before next header
		push_packet(1, 4'd0, l34ck_pkg::PR_TCP, 16'd39, 79, 0, 1, 1);   // IPv6 length too small
		push_packet(0, 4'd5, l34ck_pkg::PR_TCP, 16'd20, 10, 0, 1, 0);   // dropped by a new first
		push_packet(0, 4'd5, l34ck_pkg::PR_UDP, 16'd20, 40, 2, 1, 1);

		// UDP sum that complements to zero and goes out as all ones
		for (i = 0; i < 40; i++)
			pk.push_back(8'h00);
		pk[0] = 8'h45;
		pk[26] = 8'h12;
		pk[27] = 8'h34;
		pk[28] = 8'hff;
		pk[29] = 8'hda;
		push_bytes(pk, 16'd20, l34ck_pkg::PR_UDP, 1'b1, 1'b1);

		// random packets
		while (tx_bytes.size() < 1000)
			push_random_packet(1'b0);

		// last part without idling: three packets, each marked first and closed
		quiet_at = tx_bytes.size();
		repeat (3)
			push_random_packet(1'b1);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (tx_bytes.size() != 0 || in_valid)
			@(posedge clk);
		while (csum_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (n_err == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// run limit
	initial begin
		#1_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

### filelist.f
rtl/core/l34ck_pkg.sv
rtl/core/l34ck_accum.sv
rtl/core/l34ck_finish.sv
rtl/core/l3_l4_checksum_recompute.sv
tb/l3_l4_checksum_recompute_tb.sv
